>>> design/rf433_sensor_frame_encoder_defines.svh
// Assertion helpers used by the top-level encoder file.
`ifndef RF433_SENSOR_FRAME_ENCODER_DEFINES_SVH
`define RF433_SENSOR_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RFENC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rfenc_pkg.sv
package rfenc_pkg;

    localparam int FrameBits  = 192;
    localparam int FrameBytes = FrameBits / 8;
    localparam int IdxW       = $clog2(FrameBytes);

    localparam logic [4:0]  LastIdx     = 5'(FrameBytes - 1);
    localparam logic [11:0] Preamble    = 12'h001;
    localparam logic [14:0] SyncPattern = 15'h1FFD;
    localparam logic [7:0]  ModelByte   = 8'h46;
    localparam logic [7:0]  HumidByte   = 8'd50;
    localparam logic [7:0]  DigestKey   = 8'h3E;
    localparam logic [7:0]  DigestGen   = 8'h98;
    localparam logic [7:0]  DigestXor   = 8'h64;
    localparam logic [31:0] MinPeriod   = 32'd5000;
    localparam logic [11:0] RawMax      = 12'hFFF;

    localparam logic [31:0] RstPeriod   = 32'd5000;
    localparam logic [7:0]  RstChannel  = 8'd1;

    // configuration register indexes
    localparam int CfgIdxW = 8;
    localparam logic [CfgIdxW-1:0] RegEnable   = 8'd0;
    localparam logic [CfgIdxW-1:0] RegPeriod   = 8'd1;
    localparam logic [CfgIdxW-1:0] RegChannel  = 8'd2;
    localparam logic [CfgIdxW-1:0] RegSensorId = 8'd3;

    typedef struct packed {
        logic        enable;
        logic [31:0] send_period;
        logic [7:0]  channel;
        logic [7:0]  node_id;
    } t_cfg;

    typedef logic [FrameBits-1:0] t_frame;

    // 18*T+720 with T in 1/16 degree: trunc(t*9/8)+720, clamped to 12 bits
    function automatic logic [11:0] temp_to_raw(logic signed [15:0] t);
        logic signed [19:0] ext;
        logic signed [19:0] prod;
        logic signed [19:0] adj;
        logic signed [19:0] quot;
        logic signed [19:0] sum;
        logic [11:0]        res;
        ext  = $signed({{4{t[15]}}, t});
        prod = (ext <<< 3) + ext;
        adj  = prod[19] ? 20'sd7 : 20'sd0;
        quot = (prod + adj) >>> 3;
        sum  = quot + 20'sd720;
        if (sum[19]) begin
            res = 12'd0;
        end else if (sum > 20'sd4095) begin
            res = RawMax;
        end else begin
            res = sum[11:0];
        end
        return res;
    endfunction

    function automatic logic [2:0] chan_code(logic [7:0] ch);
        logic [2:0] c;
        if (ch == 8'd0) begin
            c = 3'd0;
        end else if (ch > 8'd8) begin
            c = 3'd7;
        end else begin
            c = 3'(ch - 8'd1);
        end
        return c;
    endfunction

    // key sequence is data independent, so this folds to an XOR of constants
    function automatic logic [7:0] lfsr_digest(logic [39:0] msg);
        logic [7:0] sum;
        logic [7:0] key;
        sum = 8'h00;
        key = DigestKey;
        for (int i = 39; i >= 0; i--) begin
            if (msg[i]) begin
                sum = sum ^ key;
            end
            key = key[0] ? ((key >> 1) ^ DigestGen) : (key >> 1);
        end
        return sum;
    endfunction

    function automatic logic [15:0] manchester(logic [7:0] b);
        logic [15:0] w;
        for (int i = 0; i < 8; i++) begin
            w[2*i+1 -: 2] = b[i] ? 2'b10 : 2'b01;
        end
        return w;
    endfunction

    function automatic t_frame build_frame(t_cfg cfg, logic signed [15:0] t);
        logic [11:0] raw;
        logic [39:0] body;
        logic [49:0] rec;
        raw  = temp_to_raw(t);
        body = {ModelByte, cfg.node_id, 1'b0, chan_code(cfg.channel), raw[11:8],
                raw[7:0], HumidByte};
        rec  = {body, lfsr_digest(body) ^ DigestXor, 2'b00};
        return {Preamble, rec, SyncPattern, rec, SyncPattern, rec};
    endfunction

endpackage

>>> design/rfenc_cfg_regs.sv
module rfenc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfenc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output rfenc_pkg::t_cfg                o_cfg,
    output logic                           o_cfg_clear
);

    rfenc_pkg::t_cfg r_cfg;
    rfenc_pkg::t_cfg n_cfg;
    logic            wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (i_cfg_index)
                rfenc_pkg::RegEnable:   n_cfg.enable      = i_cfg_data[0];
                rfenc_pkg::RegPeriod:   n_cfg.send_period = i_cfg_data;
                rfenc_pkg::RegChannel:  n_cfg.channel     = i_cfg_data[7:0];
                rfenc_pkg::RegSensorId: n_cfg.node_id     = i_cfg_data[7:0];
                default:                n_cfg             = r_cfg;
            endcase
        end
    end

    // a write that changes any value restarts the send schedule
    assign o_cfg_clear = (n_cfg != r_cfg);
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b0;
            r_cfg.send_period <= rfenc_pkg::RstPeriod;
            r_cfg.channel     <= rfenc_pkg::RstChannel;
            r_cfg.node_id     <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> design/rfenc_sched.sv
module rfenc_sched (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_now_ms,
    input  logic                    i_temp_valid,
    input  logic signed [15:0]      i_temperature,
    input  rfenc_pkg::t_cfg         i_cfg,
    input  logic                    i_cfg_clear,
    input  logic                    i_tx_free,
    output logic                    o_load,
    output rfenc_pkg::t_frame       o_frame
);

    logic               r_s1_valid;
    logic [31:0]        r_now;
    logic               r_temp_valid;
    logic signed [15:0] r_temp;
    logic [31:0]        r_last_time;
    logic [31:0]        n_last_time;
    logic [31:0]        period;
    logic [31:0]        elapsed;
    logic               attempt;
    logic               want_frame;
    logic               advance;

    assign period     = (i_cfg.send_period < rfenc_pkg::MinPeriod) ? rfenc_pkg::MinPeriod
                                                                    : i_cfg.send_period;
    assign elapsed    = r_now - r_last_time;
    assign attempt    = i_cfg.enable && ((r_last_time == 32'd0) || (elapsed >= period));
    assign want_frame = attempt && r_temp_valid;
    // hold the item only while a frame is waiting for the transmitter
    assign advance    = r_s1_valid && (!want_frame || i_tx_free);
    assign o_ready    = !r_s1_valid || advance;
    assign o_load     = advance && want_frame;
    assign o_frame    = rfenc_pkg::build_frame(i_cfg, r_temp);

    always_comb begin
        n_last_time = r_last_time;
        if (i_cfg_clear) begin
            n_last_time = 32'd0;
        end else if (advance) begin
            if (!i_cfg.enable) begin
                n_last_time = 32'd0;
            end else if (attempt) begin
                n_last_time = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_last_time <= 32'd0;
        end else begin
            r_last_time <= n_last_time;
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_now        <= i_now_ms;
            r_temp_valid <= i_temp_valid;
            r_temp       <= i_temperature;
        end
    end

endmodule

>>> design/rfenc_tx.sv
module rfenc_tx (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  rfenc_pkg::t_frame           i_frame,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [15:0]                 o_chip_word,
    output logic [rfenc_pkg::IdxW-1:0]  o_byte_index,
    output logic                        o_last
);

    logic                       r_valid;
    logic [rfenc_pkg::IdxW-1:0] r_idx;
    rfenc_pkg::t_frame          r_frame;
    logic                       take;

    assign take   = r_valid && i_ready;
    assign o_last = (r_idx == rfenc_pkg::LastIdx);
    assign o_free = !r_valid || (take && o_last);

    assign o_valid      = r_valid;
    assign o_byte_index = r_idx;
    assign o_chip_word  = rfenc_pkg::manchester(r_frame[rfenc_pkg::FrameBits-1 -: 8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // advance one byte per delivered word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end else if (take) begin
            r_frame <= r_frame << 8;
        end
    end

endmodule

>>> design/rf433_sensor_frame_encoder.sv
// Path: a tick is registered in the scheduler, then its frame is loaded into the transmitter.
// Throughput: a sending tick emits 24 chip words from the frame shift register, one per
// cycle while i_ready is high; ticks that send nothing pass at one per cycle, and a sending
// tick waits only for the previous frame to drain.
// Reset (synchronous, active low): transmitter off, period 5000, channel 1, id 0,
// last attempt time cleared, no item held and no frame pending.
`include "rf433_sensor_frame_encoder_defines.svh"

module rf433_sensor_frame_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_temp_valid,
    input  logic signed [15:0]             i_temperature,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [15:0]                    o_chip_word,
    output logic [rfenc_pkg::IdxW-1:0]     o_byte_index,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfenc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    rfenc_pkg::t_cfg   cfg;
    logic              cfg_clear;
    logic              tx_free;
    logic              load;
    rfenc_pkg::t_frame frame;

    rfenc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_clear (cfg_clear)
    );

    rfenc_sched u_sched (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_now_ms      (i_now_ms),
        .i_temp_valid  (i_temp_valid),
        .i_temperature (i_temperature),
        .i_cfg         (cfg),
        .i_cfg_clear   (cfg_clear),
        .i_tx_free     (tx_free),
        .o_load        (load),
        .o_frame       (frame)
    );

    rfenc_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_frame      (frame),
        .o_free       (tx_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chip_word  (o_chip_word),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

    `RFENC_ASSERT_NOW(a_load_when_free, load, tx_free, "frame loaded over a busy transmitter")
    `RFENC_ASSERT_NEXT(a_frame_continues, o_valid && !o_last, o_valid, "frame cut short")
    `RFENC_ASSERT_NEXT(a_index_steps, o_valid && i_ready && !o_last && !load,
        o_byte_index == $past(o_byte_index) + 1'b1, "byte index skipped")
    `RFENC_ASSERT_NOW(a_preamble_byte, o_valid && (o_byte_index == '0),
        o_chip_word == 16'h5555, "first frame byte is not the preamble")

endmodule
